// File: src/b64lw_pkg.sv
// shared types, constants and the alphabet lookup for the base64 line wrapping encoder
package b64lw_pkg;

    localparam int unsigned MAX_RUN = 5;
    localparam int unsigned RUN_CNT_W = $clog2(MAX_RUN + 1);

    localparam logic [7:0] GROUPS_RESET = 8'd18;
    localparam logic [7:0] CH_PAD = 8'h3D;
    localparam logic [7:0] CH_NL = 8'h0A;

    typedef enum logic [1:0] {
        PH_A = 2'd0,
        PH_B = 2'd1,
        PH_C = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_of_run;
        logic       message_done;
    } t_out;

    // all characters caused by one input word, entry 0 goes out first
    typedef struct packed {
        t_out [MAX_RUN-1:0]   ch;
        logic [RUN_CNT_W-1:0] cnt;
    } t_run;

    function automatic logic [7:0] enc(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26) begin
            r = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            r = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            r = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            r = 8'h2B;
        end else begin
            r = 8'h2F;
        end
        return r;
    endfunction

    function automatic t_out mk(input logic [7:0] c, input logic done);
        t_out r;
        r.text_char    = c;
        r.last_of_run  = 1'b0;
        r.message_done = done;
        return r;
    endfunction

endpackage

// File: src/b64lw_encode.sv
// encoder state and the expansion of one input word into its run of characters
module b64lw_encode (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  b64lw_pkg::t_in       i_item,
    input  logic [7:0]           i_groups,
    output b64lw_pkg::t_run      o_run
);

    localparam logic [b64lw_pkg::RUN_CNT_W-1:0] RUN_ONE =
        {{(b64lw_pkg::RUN_CNT_W-1){1'b0}}, 1'b1};

    b64lw_pkg::t_phase r_phase, n_phase;
    logic [5:0] r_carry, n_carry;
    logic [7:0] r_gcount, n_gcount;
    logic [7:0] gc;
    logic [b64lw_pkg::RUN_CNT_W-1:0] k;
    b64lw_pkg::t_run run;
    logic [7:0] b;

    assign b = i_item.data_byte;

    always_comb begin
        n_phase  = r_phase;
        n_carry  = r_carry;
        n_gcount = r_gcount;
        gc       = r_gcount;
        k        = '0;
        run      = '0;
        if (i_item.has_byte) begin
            case (r_phase)
                b64lw_pkg::PH_B: begin
                    run.ch[k] = b64lw_pkg::mk(b64lw_pkg::enc(r_carry | {2'b00, b[7:4]}), 1'b0);
                    k = k + RUN_ONE;
                    n_carry = {b[3:0], 2'b00};
                    n_phase = b64lw_pkg::PH_C;
                end
                b64lw_pkg::PH_C: begin
                    run.ch[k] = b64lw_pkg::mk(b64lw_pkg::enc(r_carry | {4'b0000, b[7:6]}), 1'b0);
                    k = k + RUN_ONE;
                    run.ch[k] = b64lw_pkg::mk(b64lw_pkg::enc(b[5:0]), 1'b0);
                    k = k + RUN_ONE;
                    n_carry = '0;
                    n_phase = b64lw_pkg::PH_A;
                    gc = r_gcount + 8'd1;
                    // line full, wrap
                    if (gc == i_groups) begin
                        run.ch[k] = b64lw_pkg::mk(b64lw_pkg::CH_NL, 1'b0);
                        k = k + RUN_ONE;
                        gc = '0;
                    end
                    n_gcount = gc;
                end
                default: begin
                    run.ch[k] = b64lw_pkg::mk(b64lw_pkg::enc(b[7:2]), 1'b0);
                    k = k + RUN_ONE;
                    n_carry = {b[1:0], 4'b0000};
                    n_phase = b64lw_pkg::PH_B;
                end
            endcase
        end
        if (i_item.end_of_message) begin
            case (n_phase)
                b64lw_pkg::PH_B: begin
                    run.ch[k] = b64lw_pkg::mk(b64lw_pkg::enc(n_carry), 1'b0);
                    k = k + RUN_ONE;
                    run.ch[k] = b64lw_pkg::mk(b64lw_pkg::CH_PAD, 1'b0);
                    k = k + RUN_ONE;
                    run.ch[k] = b64lw_pkg::mk(b64lw_pkg::CH_PAD, 1'b0);
                    k = k + RUN_ONE;
                end
                b64lw_pkg::PH_C: begin
                    run.ch[k] = b64lw_pkg::mk(b64lw_pkg::enc(n_carry), 1'b0);
                    k = k + RUN_ONE;
                    run.ch[k] = b64lw_pkg::mk(b64lw_pkg::CH_PAD, 1'b0);
                    k = k + RUN_ONE;
                end
                default: begin
                end
            endcase
            run.ch[k] = b64lw_pkg::mk(b64lw_pkg::CH_NL, 1'b1);
            k = k + RUN_ONE;
            n_phase  = b64lw_pkg::PH_A;
            n_carry  = '0;
            n_gcount = '0;
        end
        if (k != '0) begin
            run.ch[k - RUN_ONE].last_of_run = 1'b1;
        end
        run.cnt = k;
    end

    assign o_run = run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= b64lw_pkg::PH_A;
            r_carry  <= '0;
            r_gcount <= '0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_carry  <= n_carry;
            r_gcount <= n_gcount;
        end
    end

endmodule

// File: src/b64lw_burst.sv
// run buffer that hands characters one per cycle, unless the output stalls, into the output register
module b64lw_burst (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  b64lw_pkg::t_run    i_run,
    output logic               o_can_load,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output b64lw_pkg::t_out    o_out_data
);

    localparam logic [b64lw_pkg::RUN_CNT_W-1:0] RUN_ONE =
        {{(b64lw_pkg::RUN_CNT_W-1){1'b0}}, 1'b1};

    b64lw_pkg::t_out [b64lw_pkg::MAX_RUN-1:0] r_buf;
    logic [b64lw_pkg::RUN_CNT_W-1:0] r_cnt;
    logic r_out_valid;
    b64lw_pkg::t_out r_out;
    logic out_load;
    logic pop;

    assign out_load   = !r_out_valid || i_out_ready;
    assign pop        = (r_cnt != '0) && out_load;
    // refill when empty or as the last character of the current run leaves
    assign o_can_load = (r_cnt == '0) || ((r_cnt == RUN_ONE) && pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_cnt <= i_run.cnt;
            end else if (pop) begin
                r_cnt <= r_cnt - RUN_ONE;
            end
            if (out_load) begin
                r_out_valid <= pop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_run.ch;
        end else if (pop) begin
            r_buf <= r_buf >> $bits(b64lw_pkg::t_out);
        end
        if (pop) begin
            r_out <= r_buf[0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: src/base64_line_wrapping_encoder_unit.sv
// top level of the streaming base64 encoder with line wrapping
// path: input register, then run buffer, then output register
// throughput: one character per cycle unless the output stalls; a run of 0 to 5 characters
// drains through the single output register; the next word loads as the last one leaves
// reset: synchronous active low; clears phase, carry, group count, empties the buffers, and
// sets groups_per_line to 18
module base64_line_wrapping_encoder_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  b64lw_pkg::t_in    i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output b64lw_pkg::t_out   o_out_data
);

    logic [7:0] r_groups;
    logic r_in_valid;
    b64lw_pkg::t_in r_in;
    logic take;
    logic can_load;
    logic accept;
    b64lw_pkg::t_run run;

    assign take       = r_in_valid && can_load;
    assign o_in_ready = !r_in_valid || take;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_groups   <= b64lw_pkg::GROUPS_RESET;
            r_in_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_groups <= i_cfg_wdata;
            end
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (take) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
    end

    b64lw_encode u_encode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_item   (r_in),
        .i_groups (r_groups),
        .o_run    (run)
    );

    b64lw_burst u_burst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (take),
        .i_run       (run),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: src/b64lw_checker.sv
// port level checks for the base64 line wrapping encoder, bound to the top level
module b64lw_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input b64lw_pkg::t_out   o_out_data
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output word changed while stalled");

    // closing newline ends the run of its word
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.message_done) |-> o_out_data.last_of_run)
        else $error("message_done without last_of_run");

    a_done_nl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.message_done) |-> (o_out_data.text_char == b64lw_pkg::CH_NL))
        else $error("message_done on a character other than newline");

    // a pad is always followed by another pad or the closing newline
    a_pad_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.text_char == b64lw_pkg::CH_PAD)
        |=> (!o_out_valid || o_out_data.text_char == b64lw_pkg::CH_PAD
             || o_out_data.message_done))
        else $error("pad not followed by pad or closing newline");

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

endmodule

bind base64_line_wrapping_encoder_unit b64lw_checker u_b64lw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
